FILE: src/rrts_pkg.sv
// Shared types and constants for the round-robin timeslice scheduler.
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int PID_W         = 4;
    localparam int NPID          = 16;
    localparam int TS_W          = 16;
    localparam int MAX_PROCS_DEF = 16;
    localparam logic [TS_W-1:0] TS_RESET = 16'd10;

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_YIELD   = 3'd1,
        REQ_ADD     = 3'd2,
        REQ_REMOVE  = 3'd3,
        REQ_BLOCK   = 3'd4,
        REQ_UNBLOCK = 3'd5,
        REQ_START   = 3'd6
    } t_req;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_DUP         = 2'd2,
        ST_EMPTY_START = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        QOP_NONE,
        QOP_REMOVE,
        QOP_APPEND
    } t_qop;

    typedef enum logic {
        QS_IDLE,
        QS_SCAN
    } t_qst;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_REM,
        S_BLK,
        S_CHECK,
        S_RM_CUR,
        S_AP_CUR,
        S_RM_NXT,
        S_AP_NXT,
        S_REPLY
    } t_sst;

    typedef struct packed {
        logic             valid;
        t_qop             op;
        logic [PID_W-1:0] pid;
    } t_q_cmd;

    typedef struct packed {
        logic             done;
        logic             empty;
        logic             full;
        logic [PID_W-1:0] head;
        logic [NPID-1:0]  inq;
    } t_q_stat;

endpackage

FILE: src/rrts_queue.sv
// Ready queue: slot memory with a scan/compact unit, append and presence bits.
`timescale 1ns / 1ps

module rrts_queue import rrts_pkg::*; #(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_cmd  i_cmd,
    output t_q_stat o_stat
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PROCS);

    logic [PID_W-1:0] r_mem [MAX_PROCS];
    logic [PID_W-1:0] r_rdata;

    t_qst             r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [NPID-1:0]  r_inq, n_inq;
    logic [PID_W-1:0] r_head, n_head;
    logic             r_done, n_done;
    logic [PID_W-1:0] r_tgt, n_tgt;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_rd_v, n_rd_v;
    logic [IW-1:0]    r_rd_at, n_rd_at;
    logic             r_found, n_found;

    logic             w_en;
    logic [IW-1:0]    w_addr;
    logic [PID_W-1:0] w_data;
    logic             rd_en;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_inq    = r_inq;
        n_head   = r_head;
        n_done   = 1'b0;
        n_tgt    = r_tgt;
        n_rd_idx = r_rd_idx;
        n_rd_v   = r_rd_v;
        n_rd_at  = r_rd_at;
        n_found  = r_found;
        w_en     = 1'b0;
        w_addr   = '0;
        w_data   = i_cmd.pid;
        rd_en    = 1'b0;
        case (r_state)
            QS_IDLE: begin
                if (i_cmd.valid) begin
                    case (i_cmd.op)
                        QOP_APPEND: begin
                            n_done = 1'b1;
                            if (r_count < CNT_MAX) begin
                                w_en             = 1'b1;
                                w_addr           = r_count[IW-1:0];
                                n_count          = r_count + CW'(1);
                                n_inq[i_cmd.pid] = 1'b1;
                            end
                        end
                        QOP_REMOVE: begin
                            if (r_inq[i_cmd.pid]) begin
                                n_tgt    = i_cmd.pid;
                                n_rd_idx = '0;
                                n_rd_v   = 1'b0;
                                n_found  = 1'b0;
                                n_state  = QS_SCAN;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            QS_SCAN: begin
                // read slot i while slot i-1 comes back; shift down after the hit
                if (r_rd_idx < r_count) begin
                    rd_en    = 1'b1;
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_rd_at  = r_rd_idx[IW-1:0];
                    n_rd_v   = 1'b1;
                end else begin
                    n_rd_v = 1'b0;
                end
                if (r_rd_v) begin
                    if (r_found) begin
                        w_en   = 1'b1;
                        w_addr = r_rd_at - IW'(1);
                        w_data = r_rdata;
                    end
                    if (r_rdata == r_tgt) begin
                        n_found = 1'b1;
                    end
                    if (CW'(r_rd_at) + CW'(1) == r_count) begin
                        n_count        = r_count - CW'(1);
                        n_inq[r_tgt]   = 1'b0;
                        n_done         = 1'b1;
                        n_rd_v         = 1'b0;
                        n_state        = QS_IDLE;
                    end
                end
            end
            default: n_state = QS_IDLE;
        endcase
        if (w_en && (w_addr == '0)) begin
            n_head = w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= QS_IDLE;
            r_count <= '0;
            r_inq   <= '0;
            r_done  <= 1'b0;
            r_rd_v  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_inq   <= n_inq;
            r_done  <= n_done;
            r_rd_v  <= n_rd_v;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head   <= n_head;
        r_tgt    <= n_tgt;
        r_rd_idx <= n_rd_idx;
        r_rd_at  <= n_rd_at;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_rd_idx[IW-1:0]];
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count >= CNT_MAX);
    assign o_stat.head  = r_head;
    assign o_stat.inq   = r_inq;

endmodule

FILE: src/rrts_seq.sv
// Request sequencer: decodes requests, runs schedule steps on the queue unit.
`timescale 1ns / 1ps

module rrts_seq import rrts_pkg::*; #(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [2:0]       i_req_type,
    input  logic [PID_W-1:0] i_process_id,
    input  logic [TS_W-1:0]  i_timeslice,
    input  t_q_stat          i_qstat,
    output t_q_cmd           o_qcmd,
    output logic             o_valid,
    output logic             o_switched,
    output logic             o_prev_valid,
    output logic [PID_W-1:0] o_prev_pid,
    output logic [PID_W-1:0] o_next_pid,
    output logic             o_current_valid,
    output logic [PID_W-1:0] o_current_pid,
    output logic             o_sched_active,
    output logic [1:0]       o_status
);

    t_sst             r_state, n_state;
    logic [TS_W-1:0]  r_phase, n_phase;
    logic [PID_W-1:0] r_cur, n_cur;
    logic             r_known, n_known;
    logic             r_run, n_run;      // current process holds running status
    logic             r_active, n_active;
    logic [PID_W-1:0] r_tgt, n_tgt;
    logic [PID_W-1:0] r_next, n_next;
    logic             r_issued, n_issued;
    logic             r_sw, n_sw;
    logic             r_pv, n_pv;
    logic [PID_W-1:0] r_pvpid, n_pvpid;
    logic [PID_W-1:0] r_nx, n_nx;
    t_status          r_st, n_st;

    t_qop             q_op;
    logic [PID_W-1:0] q_pid;
    logic             pid_ok;
    logic [TS_W:0]    phase_inc;

    assign pid_ok    = (int'(i_process_id) < MAX_PROCS);
    assign phase_inc = {1'b0, r_phase} + (TS_W+1)'(1);

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_cur    = r_cur;
        n_known  = r_known;
        n_run    = r_run;
        n_active = r_active;
        n_tgt    = r_tgt;
        n_next   = r_next;
        n_sw     = r_sw;
        n_pv     = r_pv;
        n_pvpid  = r_pvpid;
        n_nx     = r_nx;
        n_st     = r_st;
        q_op     = QOP_NONE;
        q_pid    = r_tgt;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_sw    = 1'b0;
                    n_pv    = 1'b0;
                    n_pvpid = '0;
                    n_nx    = '0;
                    n_st    = ST_OK;
                    n_tgt   = i_process_id;
                    n_state = S_REPLY;
                    case (t_req'(i_req_type))
                        REQ_TICK: begin
                            if (phase_inc >= {1'b0, i_timeslice}) begin
                                n_phase = '0;
                                if (r_active) begin
                                    n_state = S_CHECK;
                                end
                            end else begin
                                n_phase = phase_inc[TS_W-1:0];
                            end
                        end
                        REQ_YIELD: n_state = S_CHECK;
                        REQ_ADD, REQ_UNBLOCK: begin
                            if (pid_ok) begin
                                if (i_qstat.inq[i_process_id]) begin
                                    n_st = ST_DUP;
                                end else if (i_qstat.full) begin
                                    n_st = ST_FULL;
                                end else begin
                                    if (i_process_id == r_cur) begin
                                        n_run = 1'b0;
                                    end
                                    n_state = S_ADD;
                                end
                            end
                        end
                        REQ_REMOVE: begin
                            if (pid_ok) begin
                                n_state = S_REM;
                            end
                        end
                        REQ_BLOCK: begin
                            if (pid_ok) begin
                                if (i_process_id == r_cur) begin
                                    n_run = 1'b0;
                                end
                                n_state = S_BLK;
                            end
                        end
                        REQ_START: begin
                            if (i_qstat.empty) begin
                                n_st = ST_EMPTY_START;
                            end else begin
                                if (!r_known || (r_cur != i_qstat.head)) begin
                                    n_sw = 1'b1;
                                    n_nx = i_qstat.head;
                                end
                                n_cur    = i_qstat.head;
                                n_known  = 1'b1;
                                n_run    = 1'b1;
                                n_active = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD: begin
                q_op = QOP_APPEND;
                if (i_qstat.done) begin
                    n_state = S_REPLY;
                end
            end
            S_REM: begin
                q_op = QOP_REMOVE;
                if (i_qstat.done) begin
                    n_state = S_REPLY;
                end
            end
            S_BLK: begin
                q_op = QOP_REMOVE;
                if (i_qstat.done) begin
                    n_state = (r_known && (r_tgt == r_cur)) ? S_CHECK : S_REPLY;
                end
            end
            S_CHECK: begin
                n_next = i_qstat.head;
                if (i_qstat.empty || !r_active) begin
                    n_state = S_REPLY;
                end else if (r_known && (i_qstat.head == r_cur)) begin
                    n_state = S_REPLY;
                end else begin
                    n_state = (r_known && r_run) ? S_RM_CUR : S_RM_NXT;
                end
            end
            S_RM_CUR: begin
                q_op  = QOP_REMOVE;
                q_pid = r_cur;
                if (i_qstat.done) begin
                    n_state = S_AP_CUR;
                end
            end
            S_AP_CUR: begin
                q_op  = QOP_APPEND;
                q_pid = r_cur;
                if (i_qstat.done) begin
                    n_state = S_RM_NXT;
                end
            end
            S_RM_NXT: begin
                q_op  = QOP_REMOVE;
                q_pid = r_next;
                if (i_qstat.done) begin
                    n_state = S_AP_NXT;
                end
            end
            S_AP_NXT: begin
                q_op  = QOP_APPEND;
                q_pid = r_next;
                if (i_qstat.done) begin
                    n_sw    = 1'b1;
                    n_pv    = r_known;
                    n_pvpid = r_known ? r_cur : '0;
                    n_nx    = r_next;
                    n_cur   = r_next;
                    n_known = 1'b1;
                    n_run   = 1'b1;
                    n_state = S_REPLY;
                end
            end
            S_REPLY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // one command per queue step, held off until its done pulse
    assign o_qcmd.valid = (q_op != QOP_NONE) && !r_issued;
    assign o_qcmd.op    = q_op;
    assign o_qcmd.pid   = q_pid;

    always_comb begin
        n_issued = r_issued;
        if (i_qstat.done) begin
            n_issued = 1'b0;
        end else if (o_qcmd.valid) begin
            n_issued = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= '0;
            r_cur    <= '0;
            r_known  <= 1'b0;
            r_run    <= 1'b0;
            r_active <= 1'b0;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_cur    <= n_cur;
            r_known  <= n_known;
            r_run    <= n_run;
            r_active <= n_active;
            r_issued <= n_issued;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt   <= n_tgt;
        r_next  <= n_next;
        r_sw    <= n_sw;
        r_pv    <= n_pv;
        r_pvpid <= n_pvpid;
        r_nx    <= n_nx;
        r_st    <= n_st;
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_REPLY);
    assign o_switched      = r_sw;
    assign o_prev_valid    = r_pv;
    assign o_prev_pid      = r_pvpid;
    assign o_next_pid      = r_nx;
    assign o_current_valid = r_known;
    assign o_current_pid   = r_cur;
    assign o_sched_active  = r_active;
    assign o_status        = r_st;

endmodule

FILE: src/round_robin_timeslice_scheduler_unit.sv
// Top level of the round-robin timeslice scheduler.
`timescale 1ns / 1ps

// Round-robin scheduler with a timeslice. A request word (req_type,
// process_id) is taken on a clock edge with start high and busy low; busy
// then stays high until the answer word has been shown. The answer is on
// the o_* result ports for exactly one cycle, marked by o_valid, and must be
// captured then: there is no back-pressure on the result side. Ticks that do
// not reach the timeslice, start, rejected adds and unknown requests go
// straight to the answer word; an add or unblock makes one append first. A
// remove or block of a queued id walks the ready queue memory one slot per
// cycle and compacts it behind the hit. A context switch runs up to two such
// remove passes, each followed by an append, on the same queue memory; that
// scan is what sets the item time. The timeslice register (reset 10, 0
// behaves as 1) is written through the cfg channel, which is always ready;
// write it only while busy is low. The tick phase is not cleared by a
// write. No clearing pass follows reset.
module round_robin_timeslice_scheduler_unit import rrts_pkg::*; #(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_req_type,
    input  logic [PID_W-1:0] i_process_id,
    output logic             o_valid,
    output logic             o_switched,
    output logic             o_prev_valid,
    output logic [PID_W-1:0] o_prev_pid,
    output logic [PID_W-1:0] o_next_pid,
    output logic             o_current_valid,
    output logic [PID_W-1:0] o_current_pid,
    output logic             o_sched_active,
    output logic [1:0]       o_status,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [TS_W-1:0]  i_cfg_timeslice_ticks
);

    logic [TS_W-1:0] r_timeslice;
    t_q_cmd          q_cmd;
    t_q_stat         q_stat;

    // timeslice register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeslice <= TS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeslice <= i_cfg_timeslice_ticks;
        end
    end

    // sequencer: decode, tick phase, scheduling decisions
    rrts_seq #(
        .MAX_PROCS (MAX_PROCS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_req_type      (i_req_type),
        .i_process_id    (i_process_id),
        .i_timeslice     (r_timeslice),
        .i_qstat         (q_stat),
        .o_qcmd          (q_cmd),
        .o_valid         (o_valid),
        .o_switched      (o_switched),
        .o_prev_valid    (o_prev_valid),
        .o_prev_pid      (o_prev_pid),
        .o_next_pid      (o_next_pid),
        .o_current_valid (o_current_valid),
        .o_current_pid   (o_current_pid),
        .o_sched_active  (o_sched_active),
        .o_status        (o_status)
    );

    // ready queue: slot memory plus the scan/compact unit
    rrts_queue #(
        .MAX_PROCS (MAX_PROCS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    // one answer word per request, then back to idle
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !busy)
        else $error("answer word not followed by idle");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken without going busy");

    // a switch always lands on the reported next process
    a_switch_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_switched |-> o_current_valid && (o_current_pid == o_next_pid))
        else $error("switch does not match current process");

    a_reject_no_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> !o_switched && !o_prev_valid)
        else $error("rejected request reported a switch");

endmodule

FILE: test/rrts_checker.sv
`timescale 1ns / 1ps
// Scoreboard: tracks the scheduler state, predicts each answer word and compares it.

module rrts_checker import rrts_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic [2:0]       i_req_type,
    input  logic [PID_W-1:0] i_process_id,
    input  logic             i_ans_valid,
    input  logic             i_switched,
    input  logic             i_prev_valid,
    input  logic [PID_W-1:0] i_prev_pid,
    input  logic [PID_W-1:0] i_next_pid,
    input  logic             i_current_valid,
    input  logic [PID_W-1:0] i_current_pid,
    input  logic             i_sched_active,
    input  logic [1:0]       i_status,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [TS_W-1:0]  i_cfg_ticks,
    output int               o_fail_count,
    output int               o_pending
);

    typedef enum logic [1:0] {
        PS_FREE,
        PS_READY,
        PS_RUNNING,
        PS_BLOCKED
    } t_pstate;

    typedef struct packed {
        logic             sw;
        logic             pv;
        logic [PID_W-1:0] ppid;
        logic [PID_W-1:0] npid;
        logic             cv;
        logic [PID_W-1:0] cpid;
        logic             act;
        logic [1:0]       st;
    } t_answer;

    logic [PID_W-1:0] ready_q [NPID];
    int               ready_len;
    t_pstate          pstate [NPID];
    logic [PID_W-1:0] cur_pid;
    logic             cur_known;
    logic             active;
    logic [TS_W-1:0]  phase;
    logic [TS_W-1:0]  slice;
    t_answer          ans;
    t_answer          answers_due [$];
    int               fails = 0;

    assign o_fail_count = fails;

    function automatic int find_slot(logic [PID_W-1:0] pid);
        for (int i = 0; i < ready_len; i++)
            if (ready_q[i] == pid)
                return i;
        return -1;
    endfunction

    // Remove pid from the ready queue and close the gap behind it.
    function automatic void drop_pid(logic [PID_W-1:0] pid);
        int at;
        at = find_slot(pid);
        if (at < 0)
            return;
        for (int i = at; i < ready_len - 1; i++)
            ready_q[i] = ready_q[i + 1];
        ready_len--;
    endfunction

    function automatic void push_pid(logic [PID_W-1:0] pid);
        if (ready_len < NPID) begin
            ready_q[ready_len] = pid;
            ready_len++;
        end
    endfunction

    // Head of queue takes over; a still running current goes to the tail first.
    // All 4-bit ids are below MAX_PROCS, so no range checks.
    function automatic void reschedule();
        logic [PID_W-1:0] nxt;
        if (ready_len == 0 || !active)
            return;
        nxt = ready_q[0];
        if (cur_known && nxt == cur_pid)
            return;
        if (cur_known && pstate[cur_pid] == PS_RUNNING) begin
            pstate[cur_pid] = PS_READY;
            drop_pid(cur_pid);
            push_pid(cur_pid);
        end
        drop_pid(nxt);
        push_pid(nxt);
        pstate[nxt] = PS_RUNNING;
        ans.sw      = 1'b1;
        ans.pv      = cur_known;
        ans.ppid    = cur_known ? cur_pid : '0;
        ans.npid    = nxt;
        cur_pid     = nxt;
        cur_known   = 1'b1;
    endfunction

    function automatic t_answer predict_answer(logic [2:0] req, logic [PID_W-1:0] pid);
        logic [TS_W:0] nphase;
        ans = '0;
        case (req)
            REQ_TICK: begin
                // phase runs while inactive too; slice 0 wraps on every tick
                nphase = {1'b0, phase} + (TS_W+1)'(1);
                if (nphase >= {1'b0, slice}) begin
                    phase = '0;
                    reschedule();
                end else begin
                    phase = nphase[TS_W-1:0];
                end
            end
            REQ_YIELD: reschedule();
            REQ_ADD, REQ_UNBLOCK: begin
                if (find_slot(pid) >= 0) begin
                    ans.st = ST_DUP;
                end else if (ready_len >= NPID) begin
                    ans.st = ST_FULL;
                end else begin
                    pstate[pid] = PS_READY;
                    push_pid(pid);
                end
            end
            REQ_REMOVE: drop_pid(pid);
            REQ_BLOCK: begin
                pstate[pid] = PS_BLOCKED;
                drop_pid(pid);
                if (cur_known && pid == cur_pid)
                    reschedule();
            end
            REQ_START: begin
                if (ready_len == 0) begin
                    ans.st = ST_EMPTY_START;
                end else begin
                    if (!cur_known || cur_pid != ready_q[0]) begin
                        ans.sw   = 1'b1;
                        ans.npid = ready_q[0];
                    end
                    pstate[ready_q[0]] = PS_RUNNING;
                    cur_pid   = ready_q[0];
                    cur_known = 1'b1;
                    active    = 1'b1;
                end
            end
            default: ;
        endcase
        ans.cv   = cur_known;
        ans.cpid = cur_pid;
        ans.act  = active;
        return ans;
    endfunction

    task automatic report(string msg);
        $display("%t mismatch: %s", $realtime, msg);
        fails++;
    endtask

    task automatic check_field(string name, logic [PID_W-1:0] got, logic [PID_W-1:0] want);
        if (got !== want)
            report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : watch
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            ready_len = 0;
            foreach (pstate[i])
                pstate[i] = PS_FREE;
            cur_pid   = '0;
            cur_known = 1'b0;
            active    = 1'b0;
            phase     = '0;
            slice     = TS_RESET;
            answers_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                slice = i_cfg_ticks;
            if (i_ans_valid) begin
                got = {i_switched, i_prev_valid, i_prev_pid, i_next_pid,
                       i_current_valid, i_current_pid, i_sched_active, i_status};
                if (answers_due.size() == 0) begin
                    report("answer word with none outstanding");
                end else begin
                    want = answers_due.pop_front();
                    check_field("switched", PID_W'(got.sw), PID_W'(want.sw));
                    check_field("prev_valid", PID_W'(got.pv), PID_W'(want.pv));
                    check_field("prev_pid", got.ppid, want.ppid);
                    check_field("next_pid", got.npid, want.npid);
                    check_field("current_valid", PID_W'(got.cv), PID_W'(want.cv));
                    check_field("current_pid", got.cpid, want.cpid);
                    check_field("sched_active", PID_W'(got.act), PID_W'(want.act));
                    check_field("status", PID_W'(got.st), PID_W'(want.st));
                end
            end
            if (i_start && !i_busy)
                answers_due.push_back(predict_answer(i_req_type, i_process_id));
        end
        o_pending <= answers_due.size();
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: drives requests and timeslice writes into the scheduler and gives the verdict.

module tb_top;
    import rrts_pkg::*;

    // code the block must treat as a no-op
    localparam logic [2:0] REQ_UNUSED = 3'd7;
    // cycles without any handshake before the run is declared hung
    localparam int QUIET_LIMIT = 4000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [2:0]       i_req_type = '0;
    logic [PID_W-1:0] i_process_id = '0;
    logic             o_valid;
    logic             o_switched;
    logic             o_prev_valid;
    logic [PID_W-1:0] o_prev_pid;
    logic [PID_W-1:0] o_next_pid;
    logic             o_current_valid;
    logic [PID_W-1:0] o_current_pid;
    logic             o_sched_active;
    logic [1:0]       o_status;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [TS_W-1:0]  i_cfg_timeslice_ticks = '0;

    int               fail_count;
    int               pending_words;
    int               words_sent = 0;
    int               idle_pct = 0;
    int               quiet = 0;
    logic [PID_W-1:0] last_cur = '0;

    always #10 i_clk = ~i_clk;

    round_robin_timeslice_scheduler_unit dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_req_type            (i_req_type),
        .i_process_id          (i_process_id),
        .o_valid               (o_valid),
        .o_switched            (o_switched),
        .o_prev_valid          (o_prev_valid),
        .o_prev_pid            (o_prev_pid),
        .o_next_pid            (o_next_pid),
        .o_current_valid       (o_current_valid),
        .o_current_pid         (o_current_pid),
        .o_sched_active        (o_sched_active),
        .o_status              (o_status),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_timeslice_ticks (i_cfg_timeslice_ticks)
    );

    rrts_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_req_type      (i_req_type),
        .i_process_id    (i_process_id),
        .i_ans_valid     (o_valid),
        .i_switched      (o_switched),
        .i_prev_valid    (o_prev_valid),
        .i_prev_pid      (o_prev_pid),
        .i_next_pid      (o_next_pid),
        .i_current_valid (o_current_valid),
        .i_current_pid   (o_current_pid),
        .i_sched_active  (o_sched_active),
        .i_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_ticks     (i_cfg_timeslice_ticks),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words)
    );

    // Remember who ran last so blocks can aim at the running process.
    always @(posedge i_clk) begin
        if (o_valid)
            last_cur <= o_current_pid;
    end

    // Watchdog: any accepted request, answer or register write resets it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // One request word. Called right after the clock rises; returns once the
    // word has been accepted, with start still high so back-to-back words need
    // no drop of start. A random gap (start low) goes in front when idling.
    task automatic send_word(logic [2:0] req, logic [PID_W-1:0] pid);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? int'($urandom_range(1, 6)) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= req;
        i_process_id <= pid;
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    // Drop start and wait until every answer word is in. pending_words is
    // updated with a nonblocking assign, so look only after the next edge.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_slice(logic [TS_W-1:0] ticks);
        i_cfg_valid           <= 1'b1;
        i_cfg_timeslice_ticks <= ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Operations while processes are running: half are ticks so the slice
    // counter wraps, plus yields, the queue-walking block/remove and starts.
    function automatic logic [2:0] pick_run_op();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return REQ_TICK;
        else if (r < 70)
            return REQ_YIELD;
        else if (r < 85)
            return REQ_BLOCK;
        else if (r < 95)
            return REQ_REMOVE;
        return REQ_START;
    endfunction

    task automatic run_block(int n_words);
        int               stop_at;
        int               len;
        logic [2:0]       op;
        logic [PID_W-1:0] pid;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            if ($urandom_range(99) < 70) begin
                // bring some processes up, maybe (re)start, then let them run
                len = $urandom_range(1, 5);
                repeat (len)
                    send_word($urandom_range(1) ? REQ_ADD : REQ_UNBLOCK,
                              PID_W'($urandom_range(15)));
                if ($urandom_range(3) == 0)
                    send_word(REQ_START, PID_W'($urandom_range(15)));
                len = $urandom_range(2, 12);
                repeat (len) begin
                    op  = pick_run_op();
                    pid = (op == REQ_BLOCK && $urandom_range(1)) ? last_cur
                                                                 : PID_W'($urandom_range(15));
                    send_word(op, pid);
                end
            end else begin
                // noise: any code, including the unused one
                send_word(3'($urandom_range(7)), PID_W'($urandom_range(15)));
            end
        end
    endtask

    initial begin : stimulus
        logic [TS_W-1:0] slices [6];
        int              pcts [6];

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: slice 0 so every tick is a scheduling point
        write_slice('0);
        idle_pct = 29;
        send_word(REQ_START, 4'h0);      // start on empty queue
        send_word(REQ_TICK, 4'hF);       // tick while inactive
        send_word(REQ_YIELD, 4'h0);      // yield while inactive
        send_word(REQ_ADD, 4'h0);
        send_word(REQ_ADD, 4'hF);
        send_word(REQ_ADD, 4'hA);
        send_word(REQ_ADD, 4'hA);        // duplicate add
        send_word(REQ_UNBLOCK, 4'hF);    // duplicate unblock
        send_word(REQ_START, 4'h5);      // first start, no context saved
        send_word(REQ_START, 4'h0);      // repeated start
        send_word(REQ_TICK, 4'h0);       // head already running
        send_word(REQ_YIELD, 4'h0);
        send_word(REQ_BLOCK, 4'h0);      // block the running process
        send_word(REQ_YIELD, 4'h0);
        send_word(REQ_TICK, 4'h0);
        send_word(REQ_REMOVE, 4'h3);     // remove of an absent id
        send_word(REQ_REMOVE, 4'hF);
        send_word(REQ_UNBLOCK, 4'h0);
        send_word(REQ_UNUSED, 4'h9);
        send_word(REQ_BLOCK, 4'h7);      // block of an id never queued
        send_word(REQ_ADD, 4'h5);
        send_word(REQ_YIELD, 4'h0);
        send_word(REQ_REMOVE, 4'h0);
        send_word(REQ_TICK, 4'h0);

        // random blocks; slice writes land on a nonzero phase sometimes,
        // which must not clear it
        slices = '{16'd1, 16'hFFFF, 16'd3, 16'($urandom_range(2, 12)), 16'd0, 16'd10};
        pcts   = '{29, 29, 83, 83, 0, 0};
        for (int b = 0; b < 6; b++) begin
            drain();
            write_slice(slices[b]);
            idle_pct = pcts[b];
            run_block(155);
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
src/rrts_pkg.sv
src/rrts_queue.sv
src/rrts_seq.sv
src/round_robin_timeslice_scheduler_unit.sv
test/rrts_checker.sv
test/tb_top.sv
